// ----- src/efws_pkg.sv -----
// ----------------------------------------------------------------------------
// Earliest-free worker scheduler package
// Shared widths, heap entry type, sequencer states and key compare.
// ----------------------------------------------------------------------------
package efws_pkg;

  localparam int MAX_WORKERS = 64;
  localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int TIME_W      = 48;
  localparam int DUR_W       = 30;
  localparam int WID_W       = 6;
  localparam int CFG_W       = 7;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [IDX_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } heap_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_ROOT,
    ST_ROOT,
    ST_CMP_L,
    ST_CMP_R
  } state_t;

  // Order by free time, then by worker id.
  function automatic logic key_less(entry_t a, entry_t b);
    return a < b;
  endfunction

endpackage

// ----- src/efws_if.sv -----
// ----------------------------------------------------------------------------
// Earliest-free worker scheduler channels
// Job, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface efws_job_if import efws_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             new_batch;
  logic [DUR_W-1:0] duration;

  modport source (output valid, new_batch, duration, input ready);
  modport sink (input valid, new_batch, duration, output ready);
endinterface

interface efws_res_if import efws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WID_W-1:0]  worker_id;
  logic [TIME_W-1:0] start_time;

  modport source (output valid, worker_id, start_time, input ready);
  modport sink (input valid, worker_id, start_time, output ready);
endinterface

interface efws_cfg_if import efws_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] worker_count;

  modport source (output valid, worker_count, input ready);
  modport sink (input valid, worker_count, output ready);
endinterface

// ----- src/earliest_free_worker_scheduler_core.sv -----
// The result word is registered in ST_ROOT, after ST_READ_ROOT, once the output
// register is free. The core takes no new job until the sift is done; each heap
// level uses the shared key comparator twice, in ST_CMP_L and in ST_CMP_R.
// A result may wait in the output register while the sift finishes.
// Reset (synchronous, active high) sets 64 workers, all free at time zero.
// ----------------------------------------------------------------------------
// Earliest-free worker scheduler core
// Binary min-heap of (free time, worker id); each job takes the root, adds its
// duration with saturation and sifts the root down one level per compare pair.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler_core import efws_pkg::*; (
  input logic       clk,
  input logic       rst,
  efws_cfg_if.sink  cfg,
  efws_job_if.sink  job,
  efws_res_if.source res
);

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  pos_next;
  entry_t            cur;
  entry_t            cur_next;
  entry_t            best;
  entry_t            best_next;
  logic              best_child;
  logic              best_child_next;
  logic [IDX_W-1:0]  best_idx;
  logic [IDX_W-1:0]  best_idx_next;
  logic [DUR_W-1:0]  dur;
  logic [DUR_W-1:0]  dur_next;
  logic [CNT_W-1:0]  active;
  logic              out_valid;
  logic              out_valid_next;
  logic [WID_W-1:0]  out_id;
  logic [WID_W-1:0]  out_id_next;
  logic [TIME_W-1:0] out_time;
  logic [TIME_W-1:0] out_time_next;

  heap_wr_t          wr;
  logic              clear;
  logic [IDX_W-1:0]  raddr_a;
  logic [IDX_W-1:0]  raddr_b;
  entry_t            rd_a;
  entry_t            rd_b;

  logic [IDX_W+1:0]  lc;
  logic [IDX_W+1:0]  rc;
  logic              lc_ok;
  logic              rc_ok;
  logic [TIME_W:0]   sum;
  logic              sw;
  entry_t            sw_entry;
  logic [IDX_W-1:0]  sw_idx;
  logic [IDX_W+1:0]  nlc;
  logic [IDX_W+1:0]  nrc;
  logic              cfg_we;
  entry_t            cmp_a;
  entry_t            cmp_b;
  logic              cmp_lt;

  efws_heap_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .wr      (wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign lc    = {1'b0, pos, 1'b1};
  assign rc    = lc + (IDX_W+2)'(1);
  assign lc_ok = lc < (IDX_W+2)'(active);
  assign rc_ok = rc < (IDX_W+2)'(active);
  assign sum   = {1'b0, rd_a.t} + (TIME_W+1)'(dur);

  assign cmp_a  = (state == ST_CMP_R) ? rd_b : rd_a;
  assign cmp_b  = (state == ST_CMP_R) ? best : cur;
  assign cmp_lt = key_less(cmp_a, cmp_b);

  assign job.ready      = (state == ST_IDLE);
  assign cfg.ready      = (state == ST_IDLE);
  assign cfg_we         = cfg.valid && cfg.ready;
  assign res.valid      = out_valid;
  assign res.worker_id  = out_id;
  assign res.start_time = out_time;

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    cur_next        = cur;
    best_next       = best;
    best_child_next = best_child;
    best_idx_next   = best_idx;
    dur_next        = dur;
    out_valid_next  = out_valid && !res.ready;
    out_id_next     = out_id;
    out_time_next   = out_time;
    wr              = '0;
    clear           = cfg_we;
    raddr_a         = lc[IDX_W-1:0];
    raddr_b         = rc[IDX_W-1:0];
    sw              = 1'b0;
    sw_entry        = cur;
    sw_idx          = pos;
    nlc             = '0;
    nrc             = '0;
    case (state)
      ST_IDLE: begin
        if (job.valid) begin
          dur_next   = job.duration;
          pos_next   = '0;
          clear      = cfg_we || job.new_batch;
          state_next = ST_READ_ROOT;
        end
      end
      ST_READ_ROOT: begin
        raddr_a    = '0;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (!out_valid || res.ready) begin
          out_valid_next = 1'b1;
          out_id_next    = WID_W'(rd_a.id);
          out_time_next  = rd_a.t;
          cur_next.t     = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
          cur_next.id    = rd_a.id;
          state_next     = ST_CMP_L;
        end else begin
          raddr_a = '0;
        end
      end
      ST_CMP_L: begin
        if (lc_ok && cmp_lt) begin
          best_next       = rd_a;
          best_child_next = 1'b1;
          best_idx_next   = lc[IDX_W-1:0];
        end else begin
          best_next       = cur;
          best_child_next = 1'b0;
          best_idx_next   = pos;
        end
        state_next = ST_CMP_R;
      end
      ST_CMP_R: begin
        if (rc_ok && cmp_lt) begin
          sw       = 1'b1;
          sw_entry = rd_b;
          sw_idx   = rc[IDX_W-1:0];
        end else if (best_child) begin
          sw       = 1'b1;
          sw_entry = best;
          sw_idx   = best_idx;
        end
        nlc     = {1'b0, sw_idx, 1'b1};
        nrc     = nlc + (IDX_W+2)'(1);
        wr.en   = 1'b1;
        wr.addr = pos;
        wr.data = sw ? sw_entry : cur;
        if (sw) begin
          pos_next   = sw_idx;
          raddr_a    = nlc[IDX_W-1:0];
          raddr_b    = nrc[IDX_W-1:0];
          state_next = ST_CMP_L;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      active    <= CNT_W'(MAX_WORKERS);
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        if (cfg.worker_count == '0) begin
          active <= CNT_W'(1);
        end else if (int'(cfg.worker_count) > MAX_WORKERS) begin
          active <= CNT_W'(MAX_WORKERS);
        end else begin
          active <= CNT_W'(cfg.worker_count);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    cur        <= cur_next;
    best       <= best_next;
    best_child <= best_child_next;
    best_idx   <= best_idx_next;
    dur        <= dur_next;
    out_id     <= out_id_next;
    out_time   <= out_time_next;
  end

`ifndef ASSERT_OFF
  a_one_job_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (job.valid && job.ready) |=> !job.ready)
    else $error("A second job was accepted while a sift was running.");

  a_pos_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP_L || state == ST_CMP_R) |->
      ((CNT_W+1)'(pos) < (CNT_W+1)'(active)))
    else $error("Sift position left the active heap.");

  a_active_range: assert property (@(posedge clk) disable iff (rst)
    (active != '0) && (active <= CNT_W'(MAX_WORKERS)))
    else $error("Active worker count is out of range.");

  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT && state_next == ST_CMP_L) |=> (cur.t >= res.start_time))
    else $error("Updated free time is below the reported start time.");
`endif

endmodule

// ----- src/efws_heap_mem.sv -----
// ----------------------------------------------------------------------------
// Heap entry memory
// One write port, two registered read ports. Per-entry valid bits make an
// unwritten entry read as free at time zero with its own worker id.
// ----------------------------------------------------------------------------
module efws_heap_mem import efws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  heap_wr_t         wr,
  input  logic [IDX_W-1:0] raddr_a,
  input  logic [IDX_W-1:0] raddr_b,
  output entry_t           rdata_a,
  output entry_t           rdata_b
);

  entry_t                 mem [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] valid;
  entry_t                 mem_a;
  entry_t                 mem_b;
  logic                   vld_a;
  logic                   vld_b;
  logic [IDX_W-1:0]       addr_a;
  logic [IDX_W-1:0]       addr_b;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clear) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    mem_a  <= mem[raddr_a];
    mem_b  <= mem[raddr_b];
    vld_a  <= valid[raddr_a];
    vld_b  <= valid[raddr_b];
    addr_a <= raddr_a;
    addr_b <= raddr_b;
  end

  assign rdata_a = vld_a ? mem_a : entry_t'{t: '0, id: addr_a};
  assign rdata_b = vld_b ? mem_b : entry_t'{t: '0, id: addr_b};

endmodule
